[rtl/adds_pkg.sv]
// Shared types, codes and helpers for the apogee/deployment detection sequencer.
package adds_pkg;

    // Flight phases
    typedef enum logic [3:0] {
        PH_INIT     = 4'd0,
        PH_CALIB    = 4'd1,
        PH_READY    = 4'd2,
        PH_ARMED    = 4'd3,
        PH_SHADOW   = 4'd4,
        PH_ASCENT   = 4'd5,
        PH_DROGUE   = 4'd6,
        PH_TERMINAL = 4'd7,
        PH_END      = 4'd8
    } phase_t;

    // Item kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // Flight event codes
    localparam logic [3:0] EV_CALIBRATE = 4'd0;
    localparam logic [3:0] EV_RESET     = 4'd1;
    localparam logic [3:0] EV_FSTART    = 4'd2;
    localparam logic [3:0] EV_ARMED     = 4'd3;
    localparam logic [3:0] EV_FSTOP     = 4'd4;
    localparam logic [3:0] EV_DISARMED  = 4'd5;
    localparam logic [3:0] EV_LIFTOFF   = 4'd6;
    localparam logic [3:0] EV_APOGEE    = 4'd7;
    localparam logic [3:0] EV_DEPLOY    = 4'd8;
    localparam logic [3:0] EV_LANDING   = 4'd9;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPLOY_ALT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPLOY_SAMPLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_TICKS  = 3'd4;

    // Configuration reset values
    localparam logic signed [23:0] RST_APOGEE_SPEED  = 24'sd0;
    localparam logic [7:0]         RST_APOGEE_SAMPLE = 8'd5;
    localparam logic signed [31:0] RST_DEPLOY_ALT    = 32'sd89600;
    localparam logic [7:0]         RST_DEPLOY_SAMPLE = 8'd5;
    localparam logic [15:0]        RST_SHADOW_TICKS  = 16'd375;

    // Input transaction payload
    typedef struct packed {
        logic               op;
        logic [3:0]         event_code;
        logic signed [23:0] vertical_speed;
        logic signed [31:0] agl_altitude;
    } item_t;

    // Result transaction payload
    typedef struct packed {
        phase_t     phase;
        logic       filter_enable;
        logic       calibrate_pulse;
        logic       apogee_flag;
        logic       deploy_flag;
        logic [7:0] apogee_count;
        logic [7:0] deploy_count;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic signed [23:0] apogee_speed_limit;
        logic [7:0]         apogee_sample_limit;
        logic signed [31:0] deploy_altitude_limit;
        logic [7:0]         deploy_sample_limit;
        logic [15:0]        shadow_ticks;
    } cfg_t;

    // Sequencer state
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  apogee_cnt;
        logic [7:0]  deploy_cnt;
        logic [15:0] shadow_rem;
    } state_t;

    // Saturating increment of a confidence counter
    function automatic logic [7:0] sat_inc(input logic [7:0] cnt);
        return (cnt == 8'hFF) ? 8'hFF : cnt + 8'd1;
    endfunction

endpackage

[rtl/adds_cfg_regs.sv]
// Configuration register file for the detection sequencer.
module adds_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [adds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output adds_pkg::cfg_t                     cfg
);
    import adds_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_APOGEE_SPEED:  cfg_next.apogee_speed_limit    = signed'(cfg_wdata[23:0]);
                CFG_APOGEE_SAMPLE: cfg_next.apogee_sample_limit   = cfg_wdata[7:0];
                CFG_DEPLOY_ALT:    cfg_next.deploy_altitude_limit = signed'(cfg_wdata[31:0]);
                CFG_DEPLOY_SAMPLE: cfg_next.deploy_sample_limit   = cfg_wdata[7:0];
                CFG_SHADOW_TICKS:  cfg_next.shadow_ticks          = cfg_wdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.apogee_speed_limit    <= RST_APOGEE_SPEED;
            cfg_reg.apogee_sample_limit   <= RST_APOGEE_SAMPLE;
            cfg_reg.deploy_altitude_limit <= RST_DEPLOY_ALT;
            cfg_reg.deploy_sample_limit   <= RST_DEPLOY_SAMPLE;
            cfg_reg.shadow_ticks          <= RST_SHADOW_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/adds_in_reg.sv]
// Input register stage: captures one transaction and offers it to the step logic.
module adds_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  adds_pkg::item_t s_data,
    output logic            item_valid,
    input  logic            item_take,
    output adds_pkg::item_t item
);
    import adds_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/adds_step.sv]
// Combinational step: next sequencer state and result for one item.
module adds_step (
    input  adds_pkg::state_t  cur,
    input  adds_pkg::cfg_t    cfg,
    input  adds_pkg::item_t   item,
    output adds_pkg::state_t  nxt,
    output adds_pkg::result_t res
);
    import adds_pkg::*;

    logic [15:0] shadow_dec;
    logic        in_flight;

    // Count down shadow ticks, stopping at zero
    assign shadow_dec = (cur.shadow_rem != 16'd0) ? cur.shadow_rem - 16'd1 : 16'd0;

    assign in_flight = (cur.phase == PH_SHADOW) || (cur.phase == PH_ASCENT) ||
                       (cur.phase == PH_DROGUE) || (cur.phase == PH_TERMINAL);

    always_comb begin
        nxt                 = cur;
        res.filter_enable   = 1'b0;
        res.calibrate_pulse = 1'b0;
        res.apogee_flag     = 1'b0;
        res.deploy_flag     = 1'b0;
        if (item.op == OP_TICK) begin
            res.filter_enable = (cur.phase == PH_ARMED) || in_flight;
            // Apogee confidence counter in shadow and ascent
            if (cur.phase == PH_SHADOW || cur.phase == PH_ASCENT) begin
                nxt.apogee_cnt = (item.vertical_speed < cfg.apogee_speed_limit) ?
                                 sat_inc(cur.apogee_cnt) : 8'd0;
                res.apogee_flag = (cur.phase == PH_ASCENT) &&
                                  (nxt.apogee_cnt > cfg.apogee_sample_limit);
            end
            // Deployment confidence counter in drogue
            if (cur.phase == PH_DROGUE) begin
                nxt.deploy_cnt = (item.agl_altitude < cfg.deploy_altitude_limit) ?
                                 sat_inc(cur.deploy_cnt) : 8'd0;
                res.deploy_flag = nxt.deploy_cnt > cfg.deploy_sample_limit;
            end
            // Leave shadow mode when the countdown runs out
            if (cur.phase == PH_SHADOW) begin
                nxt.shadow_rem = shadow_dec;
                if (shadow_dec == 16'd0) begin
                    nxt.phase = PH_ASCENT;
                end
            end
        end else begin
            case (cur.phase)
                PH_INIT: begin
                    if (item.event_code == EV_CALIBRATE) begin
                        nxt.phase           = PH_READY;
                        res.calibrate_pulse = 1'b1;
                    end
                end
                PH_READY: begin
                    if (item.event_code == EV_CALIBRATE || item.event_code == EV_RESET) begin
                        nxt.phase           = PH_READY;
                        res.calibrate_pulse = 1'b1;
                    end else if (item.event_code == EV_FSTART ||
                                 item.event_code == EV_ARMED) begin
                        nxt.phase = PH_ARMED;
                    end
                end
                PH_ARMED: begin
                    if (item.event_code == EV_FSTOP || item.event_code == EV_DISARMED) begin
                        nxt.phase = PH_READY;
                    end else if (item.event_code == EV_LIFTOFF) begin
                        nxt.phase      = PH_SHADOW;
                        nxt.shadow_rem = cfg.shadow_ticks;
                    end
                end
                PH_SHADOW, PH_ASCENT, PH_DROGUE, PH_TERMINAL: begin
                    if (item.event_code == EV_FSTOP) begin
                        nxt.phase = PH_READY;
                    end else if (item.event_code == EV_LANDING) begin
                        nxt.phase = PH_END;
                    end else if (cur.phase == PH_ASCENT && item.event_code == EV_APOGEE) begin
                        nxt.phase = PH_DROGUE;
                    end else if (cur.phase == PH_DROGUE && item.event_code == EV_DEPLOY) begin
                        nxt.phase = PH_TERMINAL;
                    end
                end
                default: nxt = cur;
            endcase
        end
        res.phase        = nxt.phase;
        res.apogee_count = nxt.apogee_cnt;
        res.deploy_count = nxt.deploy_cnt;
    end

endmodule

[rtl/apogee_deploy_detect_sequencer_top.sv]
// Top level of the apogee/deployment detection flight-phase sequencer.
// Accepts one transaction per cycle and returns exactly one result per
// transaction: it is held in the input register, passes through the
// combinational step that does the phase and counter update, and is then
// held in the result register. Sustained rate is one item per clock as
// long as results are taken; the result register stalls the input register
// only while a result waits. Configuration writes take effect at once and
// are meant to be made while no transaction is in flight.
module apogee_deploy_detect_sequencer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  adds_pkg::item_t                    s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output adds_pkg::result_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [adds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adds_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import adds_pkg::*;

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    step_fire;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t res_reg;
    logic    m_valid_reg;
    logic    m_valid_next;

    adds_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    adds_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item_take  (step_fire),
        .item       (item)
    );

    adds_step u_step (
        .cur  (state_reg),
        .cfg  (cfg),
        .item (item),
        .nxt  (state_next),
        .res  (step_res)
    );

    // Advance when an item is held and the result slot is free or draining
    assign step_fire    = item_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = step_fire || (m_valid_reg && !m_ready);

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_INIT;
            state_reg.apogee_cnt <= 8'd0;
            state_reg.deploy_cnt <= 8'd0;
            state_reg.shadow_rem <= 16'd0;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= step_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // A stepped item always lands in the result register
    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_valid)
        else $error("stepped transaction did not reach result register");

    // State moves only with a stepped item
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_fire |=> $stable(state_reg))
        else $error("sequencer state changed without a transaction");

    // Calibration always lands in ready
    a_cal_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.calibrate_pulse) |-> (m_data.phase == PH_READY))
        else $error("calibrate pulse outside ready phase");

    // Apogee flag only reported while in ascent
    a_apogee_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.apogee_flag) |-> (m_data.phase == PH_ASCENT))
        else $error("apogee flag outside ascent");

    // Deployment flag only reported while in drogue
    a_deploy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.deploy_flag) |-> (m_data.phase == PH_DROGUE))
        else $error("deploy flag outside drogue");

endmodule
